[hw/rtl/lzrr_pkg.sv]
// Shared types and constants of the run/repeat LZ byte decompressor.
package lzrr_pkg;

    // Action codes carried by an input item.
    localparam logic [1:0] ACT_IDLE  = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // Where the byte of a result comes from.
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_LIT  = 2'd1;
    localparam logic [1:0] SRC_HIST = 2'd2;
    localparam logic [1:0] SRC_BLK  = 2'd3;

    // Repeat block store: up to 65 bytes.
    localparam int BLK_DEPTH = 65;
    localparam int BLK_AW    = 7;

    // Command byte fields.
    localparam logic [7:0] CMD_HI_BIT  = 8'h80;
    localparam logic [7:0] CMD_MID_BIT = 8'h40;
    localparam logic [7:0] CMD_EXT_BIT = 8'h20;
    localparam logic [7:0] CMD_CNT5    = 8'h1F;
    localparam logic [7:0] CMD_CNT6    = 8'h3F;
    localparam logic [7:0] CMD_CNT4    = 8'h0F;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic       byte_taken;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       finished;
        logic       overrun;
    } out_item_t;

    // Decoder verdict for one item, before the memory data is known.
    typedef struct packed {
        logic       taken;
        logic       emit;
        logic [1:0] src;
        logic [7:0] lit;
        logic       finished;
        logic       overrun;
        logic       hist_zero;
    } step_t;

endpackage

[hw/rtl/lzrr_ram.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
module lzrr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/lzrr_decoder.sv]
// Command decoder: phase machine, counters, write pointer and memory addressing.
module lzrr_decoder #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [23:0]                      cfg_data,
    input  logic                             accept,
    input  lzrr_pkg::in_item_t               item,
    output lzrr_pkg::step_t                  step,
    output logic [$clog2(HISTORY_DEPTH)-1:0] hist_rd_addr,
    output logic [$clog2(HISTORY_DEPTH)-1:0] hist_wr_addr,
    output logic                             blk_we,
    output logic [lzrr_pkg::BLK_AW-1:0]      blk_addr,
    output logic [7:0]                       blk_wdata
);

    localparam int HIST_AW = $clog2(HISTORY_DEPTH);

    localparam logic [3:0] PH_WAIT      = 4'd0;
    localparam logic [3:0] PH_FILL_EXT  = 4'd1;
    localparam logic [3:0] PH_FILL_VAL  = 4'd2;
    localparam logic [3:0] PH_FILL_EMIT = 4'd3;
    localparam logic [3:0] PH_BACK_LO   = 4'd4;
    localparam logic [3:0] PH_BACK_EMIT = 4'd5;
    localparam logic [3:0] PH_REP_CNT   = 4'd6;
    localparam logic [3:0] PH_REP_LOAD  = 4'd7;
    localparam logic [3:0] PH_REP_PLAY  = 4'd8;
    localparam logic [3:0] PH_LIT_EXT   = 4'd9;
    localparam logic [3:0] PH_LIT       = 4'd10;

    logic [3:0]         phase_reg,  phase_next;
    logic [7:0]         cmd_reg,    cmd_next;
    logic [13:0]        cnt_reg,    cnt_next;
    logic [8:0]         pass_reg,   pass_next;
    logic [6:0]         blen_reg,   blen_next;
    logic [6:0]         bpos_reg,   bpos_next;
    logic [9:0]         dist_reg,   dist_next;
    logic [7:0]         fill_reg,   fill_next;
    logic [HIST_AW-1:0] wp_reg,     wp_next;
    logic [HIST_AW:0]   hcnt_reg,   hcnt_next;
    logic [23:0]        prod_reg,   prod_next;
    logic               ovr_reg,    ovr_next;
    logic [23:0]        olen_reg;

    logic [9:0] dist_use;
    logic       have;
    logic       do_count;
    logic       do_block;
    logic [7:0] b;

    assign b            = item.in_byte;
    assign have         = (item.action == lzrr_pkg::ACT_BYTE);
    assign dist_use     = (phase_reg == PH_BACK_LO) ? {cmd_reg[1:0], b} : dist_reg;
    assign hist_rd_addr = wp_reg - HIST_AW'(dist_use) - HIST_AW'(1);
    assign hist_wr_addr = wp_reg;
    assign blk_addr     = bpos_reg;
    assign blk_wdata    = b;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        blen_next  = blen_reg;
        bpos_next  = bpos_reg;
        dist_next  = dist_reg;
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        hcnt_next  = hcnt_reg;
        prod_next  = prod_reg;
        ovr_next   = ovr_reg;
        do_count   = 1'b0;
        do_block   = 1'b0;
        blk_we     = 1'b0;
        step       = '0;

        step.hist_zero = ({1'b0, hist_rd_addr} >= hcnt_reg);

        if (item.action == lzrr_pkg::ACT_START)
        begin
            phase_next = PH_WAIT;
            cmd_next   = '0;
            cnt_next   = '0;
            pass_next  = '0;
            blen_next  = '0;
            bpos_next  = '0;
            dist_next  = '0;
            fill_next  = '0;
            wp_next    = '0;
            hcnt_next  = '0;
            prod_next  = '0;
            ovr_next   = 1'b0;
        end
        else
        begin
            if (prod_reg < olen_reg)
            begin
                unique case (phase_reg)
                    PH_FILL_EMIT:
                    begin
                        step.emit = 1'b1;
                        step.src  = lzrr_pkg::SRC_LIT;
                        step.lit  = fill_reg;
                        do_count  = 1'b1;
                    end
                    PH_BACK_EMIT:
                    begin
                        step.emit = 1'b1;
                        step.src  = lzrr_pkg::SRC_HIST;
                        do_count  = 1'b1;
                    end
                    PH_REP_PLAY:
                    begin
                        step.emit = 1'b1;
                        step.src  = lzrr_pkg::SRC_BLK;
                        do_block  = 1'b1;
                    end
                    PH_WAIT:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            cmd_next   = b;
                            if ((b & lzrr_pkg::CMD_HI_BIT) != 8'd0)
                            begin
                                if ((b & lzrr_pkg::CMD_MID_BIT) != 8'd0)
                                begin
                                    cnt_next   = 14'(b & lzrr_pkg::CMD_CNT5) + 14'd2;
                                    phase_next = ((b & lzrr_pkg::CMD_EXT_BIT) != 8'd0) ?
                                                 PH_FILL_EXT : PH_FILL_VAL;
                                end
                                else
                                begin
                                    phase_next = PH_BACK_LO;
                                end
                            end
                            else if ((b & lzrr_pkg::CMD_MID_BIT) != 8'd0)
                            begin
                                phase_next = PH_REP_CNT;
                            end
                            else
                            begin
                                cnt_next   = 14'(b & lzrr_pkg::CMD_CNT5) + 14'd1;
                                phase_next = ((b & lzrr_pkg::CMD_EXT_BIT) != 8'd0) ?
                                             PH_LIT_EXT : PH_LIT;
                            end
                        end
                    end
                    PH_FILL_EXT:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            cnt_next   = 14'(cmd_reg & lzrr_pkg::CMD_CNT5) + 14'd2
                                         + {1'b0, b, 5'd0};
                            phase_next = PH_FILL_VAL;
                        end
                    end
                    PH_FILL_VAL:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            step.emit  = 1'b1;
                            step.src   = lzrr_pkg::SRC_LIT;
                            step.lit   = b;
                            fill_next  = b;
                            phase_next = PH_FILL_EMIT;
                            do_count   = 1'b1;
                        end
                    end
                    PH_BACK_LO:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            step.emit  = 1'b1;
                            step.src   = lzrr_pkg::SRC_HIST;
                            dist_next  = dist_use;
                            cnt_next   = 14'((cmd_reg >> 2) & lzrr_pkg::CMD_CNT4) + 14'd2;
                            phase_next = PH_BACK_EMIT;
                            do_count   = 1'b1;
                        end
                    end
                    PH_REP_CNT:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            pass_next  = {1'b0, b} + 9'd1;
                            blen_next  = 7'(cmd_reg & lzrr_pkg::CMD_CNT6) + 7'd2;
                            bpos_next  = '0;
                            phase_next = PH_REP_LOAD;
                        end
                    end
                    PH_REP_LOAD:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            step.emit  = 1'b1;
                            step.src   = lzrr_pkg::SRC_LIT;
                            step.lit   = b;
                            blk_we     = 1'b1;
                            do_block   = 1'b1;
                        end
                    end
                    PH_LIT_EXT:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            cnt_next   = 14'(cmd_reg & lzrr_pkg::CMD_CNT5) + 14'd1
                                         + {1'b0, b, 5'd0};
                            phase_next = PH_LIT;
                        end
                    end
                    PH_LIT:
                    begin
                        if (have)
                        begin
                            step.taken = 1'b1;
                            step.emit  = 1'b1;
                            step.src   = lzrr_pkg::SRC_LIT;
                            step.lit   = b;
                            do_count   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (have)
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                endcase
            end

            if (do_count)
            begin
                cnt_next = cnt_next - 14'd1;
                if (cnt_next == 14'd0)
                begin
                    phase_next = PH_WAIT;
                end
            end

            if (do_block)
            begin
                bpos_next = bpos_reg + 7'd1;
                if (bpos_next >= blen_reg)
                begin
                    bpos_next  = '0;
                    pass_next  = pass_reg - 9'd1;
                    phase_next = (pass_next == 9'd0) ? PH_WAIT : PH_REP_PLAY;
                end
            end

            if (step.emit)
            begin
                wp_next   = wp_reg + HIST_AW'(1);
                hcnt_next = (hcnt_reg == (HIST_AW + 1)'(HISTORY_DEPTH)) ?
                            hcnt_reg : hcnt_reg + (HIST_AW + 1)'(1);
                prod_next = prod_reg + 24'd1;
            end

            // A command cut short by the length limit is dropped and flagged.
            if ((prod_next >= olen_reg) && (phase_next != PH_WAIT))
            begin
                ovr_next   = 1'b1;
                phase_next = PH_WAIT;
            end
        end

        step.finished = (prod_next >= olen_reg);
        step.overrun  = ovr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            cmd_reg   <= '0;
            cnt_reg   <= '0;
            pass_reg  <= '0;
            blen_reg  <= '0;
            bpos_reg  <= '0;
            dist_reg  <= '0;
            fill_reg  <= '0;
            wp_reg    <= '0;
            hcnt_reg  <= '0;
            prod_reg  <= '0;
            ovr_reg   <= 1'b0;
            olen_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                cnt_reg   <= cnt_next;
                pass_reg  <= pass_next;
                blen_reg  <= blen_next;
                bpos_reg  <= bpos_next;
                dist_reg  <= dist_next;
                fill_reg  <= fill_next;
                wp_reg    <= wp_next;
                hcnt_reg  <= hcnt_next;
                prod_reg  <= prod_next;
                ovr_reg   <= ovr_next;
            end
            if (cfg_we)
            begin
                olen_reg <= cfg_data;
            end
        end
    end

endmodule

[hw/rtl/lz_run_repeat_decompressor_core.sv]
// Top level of the run/repeat LZ byte decompressor.
//
// Usage: each input transfer on in_valid/in_stall is one tick of the decoder.
// The tick's action is idle, offer a compressed byte, or start a new stream.
// Every input transfer yields exactly one result transfer on res_valid/res_stall,
// which reports whether the offered byte was consumed, an optional output
// byte, and the finished and overrun flags after that tick.
// The output length is set through the cfg channel (always ready) and must
// only be written while no transfer is in flight.
// The result of a transfer is registered and presented in the next
// cycle. Throughput is one transfer per cycle; the history memory's single
// read port and single write port are each used at most once per tick, and a
// byte still waiting to be written is forwarded to a read of the same entry.
// A stalled result holds the input side: in_stall is raised only while a
// result is presented and res_stall is high, so no result is dropped.
// Reset clears all control state; the history needs no clearing pass because
// a fill count marks entries never written since the stream start, and those
// read as zero. Starting a stream works the same way.
module lz_run_repeat_decompressor_core #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  lzrr_pkg::in_item_t  in_data,
    output logic                res_valid,
    input  logic                res_stall,
    output lzrr_pkg::out_item_t res_data
);

    localparam int HIST_AW = $clog2(HISTORY_DEPTH);

    logic                        accept;
    lzrr_pkg::step_t             step;
    logic [HIST_AW-1:0]          hist_rd_addr;
    logic [HIST_AW-1:0]          hist_wr_addr;
    logic                        blk_we;
    logic [lzrr_pkg::BLK_AW-1:0] blk_addr;
    logic [7:0]                  blk_wdata;
    logic [7:0]                  hist_q;
    logic [7:0]                  blk_q;

    logic                        res_valid_reg, res_valid_next;
    lzrr_pkg::step_t             s2_reg;
    logic                        wr_pend_reg;
    logic [HIST_AW-1:0]          hwr_addr_reg;
    logic                        hfwd_reg;
    logic [7:0]                  hfwd_byte_reg;

    logic [7:0] hist_byte;
    logic [7:0] res_byte;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = res_valid_reg && res_stall;
    assign res_valid = res_valid_reg;

    lzrr_decoder #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .item         (in_data),
        .step         (step),
        .hist_rd_addr (hist_rd_addr),
        .hist_wr_addr (hist_wr_addr),
        .blk_we       (blk_we),
        .blk_addr     (blk_addr),
        .blk_wdata    (blk_wdata)
    );

    // The history byte of a tick is known only once the read data is back,
    // so the history write happens in the cycle after the transfer.
    lzrr_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (8)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_pend_reg),
        .wr_addr (hwr_addr_reg),
        .wr_data (res_byte),
        .rd_en   (accept),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_q)
    );

    // The repeat block is written at transfer time; its read data is used only
    // during playback, so a read meeting a write on the same edge is never used.
    lzrr_ram #(
        .DEPTH (lzrr_pkg::BLK_DEPTH),
        .WIDTH (8)
    ) u_blk (
        .clk     (clk),
        .wr_en   (blk_we && accept),
        .wr_addr (blk_addr),
        .wr_data (blk_wdata),
        .rd_en   (accept),
        .rd_addr (blk_addr),
        .rd_data (blk_q)
    );

    // Entries beyond the fill count read as zero; an entry whose write is
    // still pending is taken from the forwarding register.
    always_comb
    begin
        if (s2_reg.hist_zero)
        begin
            hist_byte = 8'd0;
        end
        else if (hfwd_reg)
        begin
            hist_byte = hfwd_byte_reg;
        end
        else
        begin
            hist_byte = hist_q;
        end
    end

    always_comb
    begin
        case (s2_reg.src)
            lzrr_pkg::SRC_LIT:  res_byte = s2_reg.lit;
            lzrr_pkg::SRC_HIST: res_byte = hist_byte;
            lzrr_pkg::SRC_BLK:  res_byte = blk_q;
            default:            res_byte = 8'd0;
        endcase
        if (!s2_reg.emit)
        begin
            res_byte = 8'd0;
        end
    end

    assign res_data.byte_taken = s2_reg.taken;
    assign res_data.out_valid  = s2_reg.emit;
    assign res_data.out_byte   = res_byte;
    assign res_data.finished   = s2_reg.finished;
    assign res_data.overrun    = s2_reg.overrun;

    always_comb
    begin
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            wr_pend_reg   <= accept && step.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_reg        <= step;
            hwr_addr_reg  <= hist_wr_addr;
            hfwd_reg      <= wr_pend_reg && (hwr_addr_reg == hist_rd_addr);
            hfwd_byte_reg <= res_byte;
        end
    end

    // A pending history write always belongs to the emitted byte on display.
    a_wr_pend_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (res_valid_reg && res_data.out_valid))
        else $error("history write pending without an emitted result byte");

    // Only a tick that offers a byte can consume one.
    a_taken_needs_offer: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.action != lzrr_pkg::ACT_BYTE)) |=> !res_data.byte_taken)
        else $error("byte consumed on a tick that offered none");

    // The overrun flag clears only on a stream start.
    a_overrun_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid_reg && res_data.overrun
         && (in_data.action != lzrr_pkg::ACT_START)) |=> res_data.overrun)
        else $error("overrun flag dropped without a stream start");

endmodule
